// File: src/text_console_writer_unit_defines.svh
// ---------------------------------------------------------------------------
// Text console writer: assertion macros
// Shared property shorthands, clocked on clk_i and disabled while in reset.
// ---------------------------------------------------------------------------
`ifndef TEXT_CONSOLE_WRITER_UNIT_DEFINES_SVH
`define TEXT_CONSOLE_WRITER_UNIT_DEFINES_SVH

// The consequent must hold in the same cycle as the antecedent.
`define TCW_ASSERT_SAME(label, ante, cons) \
  label: assert property (@(posedge clk_i) disable iff (!rst_ni) (ante) |-> (cons)) \
    else $error("text console writer: same-cycle check failed");

// The consequent must hold in the cycle after the antecedent.
`define TCW_ASSERT_NEXT(label, ante, cons) \
  label: assert property (@(posedge clk_i) disable iff (!rst_ni) (ante) |=> (cons)) \
    else $error("text console writer: next-cycle check failed");

`endif

// File: src/tcw_pkg.sv
// ---------------------------------------------------------------------------
// Text console writer package
// Screen geometry, derived widths, character codes and the control and
// status bundles between the controller and the datapath.
// ---------------------------------------------------------------------------
`default_nettype none

package tcw_pkg;

  localparam int COLUMNS  = 80;
  localparam int ROWS     = 25;
  localparam int CELLS    = COLUMNS * ROWS;
  localparam int TAB_STOP = 8;

  localparam int ADDR_W = $clog2(CELLS);
  localparam int CNT_W  = $clog2(CELLS + 1);
  localparam int COL_W  = $clog2(COLUMNS);
  localparam int ROW_W  = $clog2(ROWS);
  localparam int CHAR_W = 8;
  localparam int ATTR_W = 8;
  localparam int CELL_W = CHAR_W + ATTR_W;

  localparam logic [CHAR_W-1:0] CH_BS    = 8'h08;
  localparam logic [CHAR_W-1:0] CH_TAB   = 8'h09;
  localparam logic [CHAR_W-1:0] CH_LF    = 8'h0A;
  localparam logic [CHAR_W-1:0] CH_CR    = 8'h0D;
  localparam logic [CHAR_W-1:0] CH_SPACE = 8'h20;

  localparam logic              REG_TEXT_ATTR = 1'b0;
  localparam logic [ATTR_W-1:0] ATTR_RESET    = 8'h0F;

  typedef struct packed {
    logic accept;
    logic clear;
    logic scroll;
  } tcw_cmd_t;

  typedef struct packed {
    logic need_scroll;
    logic clear_last;
    logic scroll_last;
  } tcw_stat_t;

endpackage

`default_nettype wire

// File: src/tcw_ram.sv
// ---------------------------------------------------------------------------
// Generic RAM
// One write port and one read port with registered read data.
// ---------------------------------------------------------------------------
`default_nettype none

module tcw_ram #(
  parameter int WIDTH = 16,
  parameter int DEPTH = 2000
) (
  input  wire logic                     clk_i,
  input  wire logic                     we_i,
  input  wire logic [$clog2(DEPTH)-1:0] waddr_i,
  input  wire logic [WIDTH-1:0]         wdata_i,
  input  wire logic                     re_i,
  input  wire logic [$clog2(DEPTH)-1:0] raddr_i,
  output logic      [WIDTH-1:0]         rdata_o
);

  logic [WIDTH-1:0] mem_q [DEPTH];

  always_ff @(posedge clk_i) begin
    if (we_i) begin
      mem_q[waddr_i] <= wdata_i;
    end
    if (re_i) begin
      rdata_o <= mem_q[raddr_i];
    end
  end

endmodule

`default_nettype wire

// File: src/tcw_ctrl.sv
// ---------------------------------------------------------------------------
// Text console writer controller
// Sequences the clearing pass after reset, item acceptance and the scroll.
// ---------------------------------------------------------------------------
`default_nettype none

module tcw_ctrl (
  input  wire logic              clk_i,
  input  wire logic              rst_ni,
  input  wire logic              start_i,
  input  wire tcw_pkg::tcw_stat_t stat_i,
  output tcw_pkg::tcw_cmd_t      cmd_o,
  output logic                   busy_o,
  output logic                   done_o
);

  localparam logic [1:0] S_CLEAR  = 2'd0;
  localparam logic [1:0] S_IDLE   = 2'd1;
  localparam logic [1:0] S_SCROLL = 2'd2;

  logic [1:0] state_q, state_d;
  logic       done_q, done_d;

  always_comb begin
    state_d = state_q;
    done_d  = 1'b0;
    cmd_o   = '0;
    unique case (state_q)
      S_CLEAR: begin
        cmd_o.clear = 1'b1;
        if (stat_i.clear_last) begin
          state_d = S_IDLE;
        end
      end
      S_IDLE: begin
        if (start_i) begin
          cmd_o.accept = 1'b1;
          if (stat_i.need_scroll) begin
            state_d = S_SCROLL;
          end else begin
            done_d = 1'b1;
          end
        end
      end
      S_SCROLL: begin
        cmd_o.scroll = 1'b1;
        if (stat_i.scroll_last) begin
          state_d = S_IDLE;
          done_d  = 1'b1;
        end
      end
      default: begin
        state_d = S_IDLE;
      end
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q <= S_CLEAR;
      done_q  <= 1'b0;
    end else begin
      state_q <= state_d;
      done_q  <= done_d;
    end
  end

  assign busy_o = (state_q != S_IDLE);
  assign done_o = done_q;

endmodule

`default_nettype wire

// File: src/tcw_datapath.sv
// ---------------------------------------------------------------------------
// Text console writer datapath
// Cursor registers, character decode, the sweep counter and the cell store.
// ---------------------------------------------------------------------------
`default_nettype none

module tcw_datapath (
  input  wire logic                          clk_i,
  input  wire logic                          rst_ni,
  input  wire tcw_pkg::tcw_cmd_t             cmd_i,
  output tcw_pkg::tcw_stat_t                 stat_o,
  input  wire logic                          action_i,
  input  wire logic [tcw_pkg::CHAR_W-1:0]    char_code_i,
  input  wire logic [tcw_pkg::ADDR_W-1:0]    cell_address_i,
  input  wire logic [tcw_pkg::ATTR_W-1:0]    attr_i,
  output logic      [tcw_pkg::ADDR_W-1:0]    cursor_location_o,
  output logic      [tcw_pkg::CELL_W-1:0]    cell_data_o,
  output logic                               scrolled_o
);

  localparam int AW = tcw_pkg::ADDR_W;
  localparam int CW = tcw_pkg::CNT_W;
  localparam int XW = tcw_pkg::COL_W + 1;
  localparam int YW = tcw_pkg::ROW_W + 1;

  logic [tcw_pkg::COL_W-1:0]  col_q, col_d;
  logic [tcw_pkg::ROW_W-1:0]  row_q, row_d;
  logic [CW-1:0]              cnt_q;
  logic                       rd_q, oor_q, scr_q;

  logic [XW-1:0]              col_x;
  logic [YW-1:0]              row_x;
  logic                       printable;
  logic                       need_scroll;
  logic [AW-1:0]              cur_idx;
  logic [CW:0]                src_idx;
  logic [CW-1:0]              dst_idx;
  logic                       in_range;

  logic                       ram_we, ram_re;
  logic [AW-1:0]              ram_waddr, ram_raddr;
  logic [tcw_pkg::CELL_W-1:0] ram_wdata, ram_rdata;

  assign cur_idx = AW'(row_q) * AW'(tcw_pkg::COLUMNS) + AW'(col_q);
  assign printable = !char_code_i[tcw_pkg::CHAR_W-1] && (char_code_i >= tcw_pkg::CH_SPACE);

  always_comb begin
    col_x = XW'(col_q);
    row_x = YW'(row_q);
    case (char_code_i)
      tcw_pkg::CH_BS: begin
        if (col_q != '0) begin
          col_x = col_x - XW'(1);
        end
      end
      tcw_pkg::CH_TAB: begin
        col_x = (col_x + XW'(tcw_pkg::TAB_STOP)) & ~XW'(tcw_pkg::TAB_STOP - 1);
      end
      tcw_pkg::CH_CR: begin
        col_x = '0;
      end
      tcw_pkg::CH_LF: begin
        col_x = '0;
        row_x = row_x + YW'(1);
      end
      default: begin
        if (printable) begin
          col_x = col_x + XW'(1);
        end
      end
    endcase
    if (col_x >= XW'(tcw_pkg::COLUMNS)) begin
      col_x = '0;
      row_x = row_x + YW'(1);
    end
    need_scroll = !action_i && (row_x >= YW'(tcw_pkg::ROWS));
    col_d = col_x[tcw_pkg::COL_W-1:0];
    row_d = need_scroll ? tcw_pkg::ROW_W'(tcw_pkg::ROWS - 1) : row_x[tcw_pkg::ROW_W-1:0];
  end

  assign in_range = CW'(cell_address_i) < CW'(tcw_pkg::CELLS);
  assign src_idx  = (CW + 1)'(cnt_q) + (CW + 1)'(tcw_pkg::COLUMNS);
  assign dst_idx  = cnt_q - CW'(1);

  always_comb begin
    ram_we    = 1'b0;
    ram_waddr = cur_idx;
    ram_wdata = {attr_i, char_code_i};
    ram_re    = 1'b0;
    ram_raddr = cell_address_i;
    if (cmd_i.clear) begin
      ram_we    = 1'b1;
      ram_waddr = cnt_q[AW-1:0];
      ram_wdata = '0;
    end else if (cmd_i.scroll) begin
      ram_re    = src_idx < (CW + 1)'(tcw_pkg::CELLS);
      ram_raddr = src_idx[AW-1:0];
      ram_we    = (cnt_q != '0);
      ram_waddr = dst_idx[AW-1:0];
      if (dst_idx < CW'(tcw_pkg::CELLS - tcw_pkg::COLUMNS)) begin
        ram_wdata = ram_rdata;
      end else begin
        ram_wdata = {attr_i, tcw_pkg::CH_SPACE};
      end
    end else if (cmd_i.accept) begin
      ram_we = !action_i && printable;
      ram_re = action_i && in_range;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      col_q <= '0;
      row_q <= '0;
      cnt_q <= '0;
      rd_q  <= 1'b0;
      oor_q <= 1'b0;
      scr_q <= 1'b0;
    end else begin
      if (cmd_i.clear || cmd_i.scroll) begin
        if (stat_o.clear_last && cmd_i.clear) begin
          cnt_q <= '0;
        end else if (stat_o.scroll_last && cmd_i.scroll) begin
          cnt_q <= '0;
        end else begin
          cnt_q <= cnt_q + CW'(1);
        end
      end
      if (cmd_i.accept) begin
        rd_q  <= action_i;
        oor_q <= !in_range;
        scr_q <= need_scroll;
        if (!action_i) begin
          col_q <= col_d;
          row_q <= row_d;
        end
      end
    end
  end

  tcw_ram #(
    .WIDTH (tcw_pkg::CELL_W),
    .DEPTH (tcw_pkg::CELLS)
  ) u_frame_store (
    .clk_i   (clk_i),
    .we_i    (ram_we),
    .waddr_i (ram_waddr),
    .wdata_i (ram_wdata),
    .re_i    (ram_re),
    .raddr_i (ram_raddr),
    .rdata_o (ram_rdata)
  );

  assign stat_o.need_scroll = need_scroll;
  assign stat_o.clear_last  = (cnt_q == CW'(tcw_pkg::CELLS - 1));
  assign stat_o.scroll_last = (cnt_q == CW'(tcw_pkg::CELLS));

  assign cursor_location_o = cur_idx;
  assign cell_data_o       = (rd_q && !oor_q) ? ram_rdata : '0;
  assign scrolled_o        = scr_q;

endmodule

`default_nettype wire

// File: src/text_console_writer_unit.sv
// ---------------------------------------------------------------------------
// Text console writer
// An 80x25 text console: puts bytes at a cursor, scrolls, and reads cells.
// ---------------------------------------------------------------------------
// After reset the block holds busy high while it clears the frame store
// one cell per cycle. A read or a put that does not scroll is taken while
// busy is low, and its result appears on done_o in the next cycle.
// A put that scrolls moves the screen through the single write port of the
// frame store, one cell per cycle, so busy stays high during the move and
// its result appears as busy falls. Every result beat stands for exactly
// one cycle and cannot be stalled by the receiver.
`default_nettype none

`include "text_console_writer_unit_defines.svh"

module text_console_writer_unit (
  input  wire logic                       clk_i,
  input  wire logic                       rst_ni,
  input  wire logic                       start,
  output logic                            busy,
  output logic                            done_o,
  input  wire logic                       action_i,
  input  wire logic [tcw_pkg::CHAR_W-1:0] char_code_i,
  input  wire logic [tcw_pkg::ADDR_W-1:0] cell_address_i,
  output logic      [tcw_pkg::ADDR_W-1:0] cursor_location_o,
  output logic      [tcw_pkg::CELL_W-1:0] cell_data_o,
  output logic                            scrolled_o,
  input  wire logic                       psel,
  input  wire logic                       penable,
  input  wire logic                       pwrite,
  input  wire logic [2:0]                 paddr,
  input  wire logic [31:0]                pwdata,
  output logic      [31:0]                prdata,
  output logic                            pready
);

  tcw_pkg::tcw_cmd_t          cmd;
  tcw_pkg::tcw_stat_t         stat;
  logic [tcw_pkg::ATTR_W-1:0] attr_q;
  logic                       cfg_wr;

  assign pready = 1'b1;
  assign cfg_wr = psel && penable && pwrite && pready && (paddr[2] == tcw_pkg::REG_TEXT_ATTR);
  assign prdata = (paddr[2] == tcw_pkg::REG_TEXT_ATTR) ? 32'(attr_q) : '0;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      attr_q <= tcw_pkg::ATTR_RESET;
    end else if (cfg_wr) begin
      attr_q <= pwdata[tcw_pkg::ATTR_W-1:0];
    end
  end

  tcw_ctrl u_ctrl (
    .clk_i   (clk_i),
    .rst_ni  (rst_ni),
    .start_i (start),
    .stat_i  (stat),
    .cmd_o   (cmd),
    .busy_o  (busy),
    .done_o  (done_o)
  );

  tcw_datapath u_datapath (
    .clk_i             (clk_i),
    .rst_ni            (rst_ni),
    .cmd_i             (cmd),
    .stat_o            (stat),
    .action_i          (action_i),
    .char_code_i       (char_code_i),
    .cell_address_i    (cell_address_i),
    .attr_i            (attr_q),
    .cursor_location_o (cursor_location_o),
    .cell_data_o       (cell_data_o),
    .scrolled_o        (scrolled_o)
  );

  `TCW_ASSERT_SAME(a_done_idle, done_o, !busy)
  `TCW_ASSERT_NEXT(a_read_one_cycle, start && !busy && action_i, done_o && !scrolled_o)
  `TCW_ASSERT_NEXT(a_scroll_holds_busy, start && !busy && stat.need_scroll, busy && !done_o)
  `TCW_ASSERT_SAME(a_scroll_last_row, done_o && scrolled_o,
                   cursor_location_o >= tcw_pkg::ADDR_W'((tcw_pkg::ROWS - 1) * tcw_pkg::COLUMNS))

endmodule

`default_nettype wire
